// File: design/segregated_page_allocator_macros.svh
// Assertion macros shared by the allocator RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef SEGREGATED_PAGE_ALLOCATOR_MACROS_SVH
`define SEGREGATED_PAGE_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page allocator check failed");

`endif

// File: design/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spa_pkg;

    localparam int ADDR_W   = 27;
    localparam int BYTES_W  = 25;
    localparam int SIZE_W   = 32;
    localparam int SHIFT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 5'd8;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 5'd20;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd16;

    // Register index, taken from paddr[2].
    localparam logic REG_MIN_PAGE_SHIFT = 1'b0;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SIZE   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAGE    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ADDR_RANGE = 2'd3;

    typedef struct packed {
        logic               op;
        logic [SIZE_W-1:0]  req_size;
        logic [ADDR_W-1:0]  free_addr;
        logic [BYTES_W-1:0] free_bytes;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   block_addr;
        logic [BYTES_W-1:0]  block_bytes;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_SCAN,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: design/segregated_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                 Direction  Transaction
// --------  --------------------------------------  ---------  ---------------------------------
// req       req_valid, req_stall, req (req_t)        in         allocate or free request
// rsp       rsp_valid, rsp_stall, rsp (rsp_t)        out        status, block address and size
// apb       psel, penable, pwrite, paddr, pwdata,    in/out     min_page_shift register access
//           prdata, pready
//
// An allocate transaction passes from acceptance through the decode state, then a read
// state and a scan state for each heap examined (1 to MAX_HEAPS), then the output state,
// which loads its result into the output register; the scan reads one bitmap word per heap.
// A free transaction passes through the decode, read, scan and output states; a request with
// a bad size or an out-of-range address goes from decode straight to output. The block then
// returns to idle before the next request is taken. After reset the bitmap memory is cleared
// one word per cycle, (MAX_ORDER+1)*MAX_HEAPS words in all (40 with the default parameters);
// no request is taken during that pass, while register writes are accepted as always.
// A stalled result waits in the output register; the block still accepts a new request,
// but that request cannot hand over its own result until the waiting one is taken.

module segregated_page_allocator #(
    parameter int MAX_ORDER = 4,
    parameter int MAX_HEAPS = 8
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_stall,
    input  wire  spa_pkg::req_t               req,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output spa_pkg::rsp_t                     rsp,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [spa_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire  [spa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    import spa_pkg::*;

    // The bitmap holds one word per heap of every class. A word has one bit per page of a
    // class 0 heap; a heap of class k uses only its lowest 2^(MAX_ORDER-k) bits.
    localparam int PAGE_W  = MAX_ORDER;
    localparam int PER0    = 1 << MAX_ORDER;
    localparam int NWORDS  = (MAX_ORDER + 1) * MAX_HEAPS;
    localparam int WADDR_W = $clog2(NWORDS);
    localparam int CLS_W   = $clog2(MAX_ORDER + 1);
    localparam int HEAP_W  = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
    localparam int SHAMT_W = $clog2(20 + MAX_ORDER + 1);

    state_t state_reg, state_next;
    logic [WADDR_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic [SHIFT_W-1:0] min_page_shift_reg, min_page_shift_next;
    logic rsp_valid_reg, rsp_valid_next;

    req_t req_hold_reg, req_hold_next;
    logic [CLS_W-1:0] class_reg, class_next;
    logic [HEAP_W-1:0] heap_cnt_reg, heap_cnt_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    rsp_t res_reg, res_next;
    rsp_t rsp_reg, rsp_next;

    logic [PER0-1:0] bitmap_mem [NWORDS];
    logic [PER0-1:0] mem_rdata_reg;
    logic            mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [PER0-1:0] mem_wdata;
    logic [WADDR_W-1:0] word_addr;

    logic [SHIFT_W-1:0] sh_eff;
    logic [SHAMT_W-1:0] sh_w;
    logic [SHAMT_W-1:0] sh_top;
    logic [SHAMT_W-1:0] sh_cls;
    logic [SIZE_W-1:0] dec_size;
    logic [SIZE_W-1:0] dec_pm1;
    logic dec_bad;
    logic dec_oob;
    logic [CLS_W-1:0] dec_class;
    logic [SHAMT_W-1:0] dec_sh_cls;
    logic [ADDR_W-1:0] dec_heap_full;
    logic [ADDR_W-1:0] dec_page_full;
    logic [PAGE_W-1:0] dec_page;
    logic [PAGE_W-1:0] dec_page_mask;

    logic [PER0-1:0] word_mask;
    logic scan_hit;
    logic [PAGE_W-1:0] hit_idx;
    logic heap_last;
    logic rsp_free;
    logic cfg_write;

    // ------------------------------------------------------------------
    // Configuration port. A single register, selected by paddr[2].
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == REG_MIN_PAGE_SHIFT);

    always_comb
    begin
        min_page_shift_next = min_page_shift_reg;
        if (cfg_write)
        begin
            min_page_shift_next = pwdata[SHIFT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MIN_PAGE_SHIFT)
        begin
            prdata = {{(APB_DATA_W - SHIFT_W){1'b0}}, min_page_shift_reg};
        end
    end

    // Out-of-range register values are clamped to the supported page sizes.
    always_comb
    begin
        if (min_page_shift_reg < SHIFT_MIN)
        begin
            sh_eff = SHIFT_MIN;
        end
        else if (min_page_shift_reg > SHIFT_MAX)
        begin
            sh_eff = SHIFT_MAX;
        end
        else
        begin
            sh_eff = min_page_shift_reg;
        end
    end

    assign sh_w   = SHAMT_W'(sh_eff);
    assign sh_top = sh_w + SHAMT_W'(MAX_ORDER);
    assign sh_cls = sh_w + SHAMT_W'(class_reg);

    // ------------------------------------------------------------------
    // Request decode. The page count minus one is (size - 1) >> shift, so
    // the class is the bit length of that value and a size above the top
    // page leaves bits at or above MAX_ORDER.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (req_hold_reg.op == OP_FREE)
        begin
            dec_size = SIZE_W'(req_hold_reg.free_bytes);
        end
        else
        begin
            dec_size = req_hold_reg.req_size;
        end
        dec_pm1 = (dec_size - SIZE_W'(1)) >> sh_w;
        dec_bad = (dec_size == '0) || ((dec_pm1 >> MAX_ORDER) != '0);

        dec_class = '0;
        for (int b = 0; b < MAX_ORDER; b++)
        begin
            if (dec_pm1[b])
            begin
                dec_class = CLS_W'(b + 1);
            end
        end

        dec_sh_cls    = sh_w + SHAMT_W'(dec_class);
        dec_heap_full = req_hold_reg.free_addr >> sh_top;
        dec_oob       = (req_hold_reg.op == OP_FREE)
                        && (dec_heap_full >= ADDR_W'(MAX_HEAPS));
        dec_page_full = req_hold_reg.free_addr >> dec_sh_cls;
        // A class k heap has 2^(MAX_ORDER-k) pages, so the page index keeps MAX_ORDER-k bits.
        dec_page_mask = PAGE_W'(PER0 - 1) >> dec_class;
        dec_page      = dec_page_full[PAGE_W-1:0] & dec_page_mask;
    end

    // ------------------------------------------------------------------
    // Word scan: lowest free page among the pages that the class uses.
    // ------------------------------------------------------------------
    assign word_addr = WADDR_W'(class_reg) * WADDR_W'(MAX_HEAPS) + WADDR_W'(heap_cnt_reg);
    assign heap_last = (heap_cnt_reg == HEAP_W'(MAX_HEAPS - 1));

    always_comb
    begin
        scan_hit = 1'b0;
        hit_idx  = '0;
        for (int b = PER0 - 1; b >= 0; b--)
        begin
            word_mask[b] = ((PAGE_W'(b) >> (CLS_W'(MAX_ORDER) - class_reg)) == '0);
            if (word_mask[b] && !mem_rdata_reg[b])
            begin
                scan_hit = 1'b1;
                hit_idx  = PAGE_W'(b);
            end
        end
    end

    // The output register can take a new result when empty or when its
    // current result is taken in this cycle.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_cnt_reg == WADDR_W'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (dec_bad || dec_oob)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if ((req_hold_reg.op == OP_FREE) || scan_hit || heap_last)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath and memory controls.
    // ------------------------------------------------------------------
    always_comb
    begin
        req_stall      = (state_reg != ST_IDLE);
        clear_cnt_next = clear_cnt_reg;
        req_hold_next  = req_hold_reg;
        class_next     = class_reg;
        heap_cnt_next  = heap_cnt_reg;
        page_next      = page_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;
        mem_waddr      = word_addr;
        mem_wdata      = mem_rdata_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = clear_cnt_reg;
                mem_wdata      = '0;
                clear_cnt_next = clear_cnt_reg + WADDR_W'(1);
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_hold_next = req;
                end
            end
            ST_DECODE:
            begin
                class_next = dec_class;
                page_next  = dec_page;
                res_next   = '0;
                if (req_hold_reg.op == OP_FREE)
                begin
                    heap_cnt_next = dec_heap_full[HEAP_W-1:0];
                end
                else
                begin
                    heap_cnt_next = '0;
                end
                if (dec_bad)
                begin
                    res_next.status = STATUS_BAD_SIZE;
                end
                else if (dec_oob)
                begin
                    res_next.status = STATUS_ADDR_RANGE;
                end
            end
            ST_READ:
            begin
            end
            ST_SCAN:
            begin
                if (req_hold_reg.op == OP_FREE)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_rdata_reg & ~(PER0'(1) << page_reg);
                end
                else if (scan_hit)
                begin
                    mem_we               = 1'b1;
                    mem_wdata            = mem_rdata_reg | (PER0'(1) << hit_idx);
                    res_next.block_addr  = (ADDR_W'(heap_cnt_reg) << sh_top)
                                           | (ADDR_W'(hit_idx) << sh_cls);
                    res_next.block_bytes = BYTES_W'(1) << sh_cls;
                end
                else if (heap_last)
                begin
                    res_next.status = STATUS_NO_PAGE;
                end
                else
                begin
                    heap_cnt_next = heap_cnt_reg + HEAP_W'(1);
                end
            end
            ST_OUT:
            begin
                if (rsp_free)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_CLEAR;
            clear_cnt_reg      <= '0;
            min_page_shift_reg <= SHIFT_RESET;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            clear_cnt_reg      <= clear_cnt_next;
            min_page_shift_reg <= min_page_shift_next;
            rsp_valid_reg      <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_hold_reg <= req_hold_next;
        class_reg    <= class_next;
        heap_cnt_reg <= heap_cnt_next;
        page_reg     <= page_next;
        res_reg      <= res_next;
        rsp_reg      <= rsp_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= bitmap_mem[word_addr];
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "segregated_page_allocator_macros.svh"

    `SPA_ASSERT_SAME(a_no_accept_in_clear, state_reg == ST_CLEAR, req_stall)
    `SPA_ASSERT_NEXT(a_accept_decodes, req_valid && !req_stall, state_reg == ST_DECODE)
    `SPA_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid), $past(state_reg == ST_OUT))
    `SPA_ASSERT_SAME(a_fail_zero_payload, rsp_valid && (rsp.status != STATUS_OK),
                     (rsp.block_addr == '0) && (rsp.block_bytes == '0))
    `SPA_ASSERT_SAME(a_heap_in_range, state_reg == ST_SCAN,
                     heap_cnt_reg <= HEAP_W'(MAX_HEAPS - 1))

endmodule

`default_nettype wire
